FILE: rtl/core/pip_pkg.sv
// Package for the point-in-polygon crossing block.
// Holds field widths, queue sizing and the edge classification flags type.
// Depends on nothing.
package pip_pkg;

  localparam int X_W = 29;
  localparam int Y_W = 28;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = 2;
  localparam int QUEUE_CNT_W = 3;

  typedef struct packed {
    logic in_span;
    logic dy_pos;
    logic dy_neg;
    logic last;
  } pip_flags_t;

  localparam int FLAGS_W = $bits(pip_flags_t);

endpackage

FILE: rtl/core/pip_front.sv
// Front end of the crossing block: bounds tests and coordinate differences per edge.
// Depends on pip_pkg.
module pip_front #(
  parameter int COORD_WIDTH = 32
) (
  input  logic signed [pip_pkg::X_W-1:0] query_x,
  input  logic signed [pip_pkg::Y_W-1:0] query_y,
  input  logic signed [pip_pkg::X_W-1:0] start_x,
  input  logic signed [pip_pkg::Y_W-1:0] start_y,
  input  logic signed [pip_pkg::X_W-1:0] end_x,
  input  logic signed [pip_pkg::Y_W-1:0] end_y,
  input  logic                           last_edge,
  output pip_pkg::pip_flags_t            flags,
  output logic signed [COORD_WIDTH-1:0]  dx,
  output logic signed [COORD_WIDTH-1:0]  dy,
  output logic signed [COORD_WIDTH-1:0]  qdx,
  output logic signed [COORD_WIDTH-1:0]  qdy
);

  logic signed [pip_pkg::X_W-1:0] max_x;
  logic signed [pip_pkg::Y_W-1:0] min_y;
  logic signed [pip_pkg::Y_W-1:0] max_y;
  logic signed [COORD_WIDTH-1:0]  qx_c;
  logic signed [COORD_WIDTH-1:0]  qy_c;
  logic signed [COORD_WIDTH-1:0]  ax_c;
  logic signed [COORD_WIDTH-1:0]  ay_c;
  logic signed [COORD_WIDTH-1:0]  bx_c;
  logic signed [COORD_WIDTH-1:0]  by_c;

  assign max_x = (start_x > end_x) ? start_x : end_x;
  assign min_y = (start_y < end_y) ? start_y : end_y;
  assign max_y = (start_y > end_y) ? start_y : end_y;

  assign qx_c = COORD_WIDTH'(query_x);
  assign qy_c = COORD_WIDTH'(query_y);
  assign ax_c = COORD_WIDTH'(start_x);
  assign ay_c = COORD_WIDTH'(start_y);
  assign bx_c = COORD_WIDTH'(end_x);
  assign by_c = COORD_WIDTH'(end_y);

  assign dx  = bx_c - ax_c;
  assign dy  = by_c - ay_c;
  assign qdx = qx_c - ax_c;
  assign qdy = qy_c - ay_c;

  always_comb begin
    flags.in_span = (max_x >= query_x) && (min_y <= query_y) && (query_y < max_y);
    flags.dy_neg  = dy[COORD_WIDTH-1];
    flags.dy_pos  = !dy[COORD_WIDTH-1] && (|dy);
    flags.last    = last_edge;
  end

endmodule

FILE: rtl/core/pip_queue.sv
// Short queue that decouples the front end from the multiply and compare back end.
// Depends on pip_pkg for its depth.
module pip_queue #(
  parameter int WIDTH = 132
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] pop_data
);

  localparam int DEPTH = pip_pkg::QUEUE_DEPTH;
  localparam int PTR_W = pip_pkg::QUEUE_PTR_W;
  localparam int CNT_W = pip_pkg::QUEUE_CNT_W;

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             do_push;
  logic             do_pop;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_data  = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: rtl/core/pip_back.sv
// Back end of the crossing block: split cross products, signed compare, parity and result register.
// Depends on pip_pkg for the classification flags.
module pip_back #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_not_empty,
  output logic                          q_pop,
  input  pip_pkg::pip_flags_t           q_flags,
  input  logic signed [COORD_WIDTH-1:0] q_dx,
  input  logic signed [COORD_WIDTH-1:0] q_dy,
  input  logic signed [COORD_WIDTH-1:0] q_qdx,
  input  logic signed [COORD_WIDTH-1:0] q_qdy,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_inside_res
);

  localparam int CW   = COORD_WIDTH;
  localparam int H    = CW / 2;
  localparam int LO_W = CW + H + 1;
  localparam int HI_W = 2 * CW - H;
  localparam int FW   = 2 * CW;
  localparam int PW   = (FW > 64) ? 64 : FW;

  logic                     adv;
  logic signed [H:0]        lhs_bl;
  logic signed [CW-H-1:0]   lhs_bh;
  logic signed [H:0]        rhs_bl;
  logic signed [CW-H-1:0]   rhs_bh;
  logic signed [LO_W-1:0]   lhs_lo_nxt;
  logic signed [HI_W-1:0]   lhs_hi_nxt;
  logic signed [LO_W-1:0]   rhs_lo_nxt;
  logic signed [HI_W-1:0]   rhs_hi_nxt;

  logic                     s1_valid_r;
  pip_pkg::pip_flags_t      s1_flags_r;
  logic signed [LO_W-1:0]   lhs_lo_r;
  logic signed [HI_W-1:0]   lhs_hi_r;
  logic signed [LO_W-1:0]   rhs_lo_r;
  logic signed [HI_W-1:0]   rhs_hi_r;

  logic signed [FW-1:0]     lhs_full;
  logic signed [FW-1:0]     rhs_full;
  logic signed [PW-1:0]     lhs;
  logic signed [PW-1:0]     rhs;
  logic                     counted;

  logic                     parity_r;
  logic                     out_valid_r;
  logic                     out_inside_r;

  assign adv   = !(out_valid_r && out_stall);
  assign q_pop = adv && q_not_empty;

  // The second operand is split into an unsigned low half and a signed high half.
  assign lhs_bl = signed'({1'b0, q_qdy[H-1:0]});
  assign lhs_bh = q_qdy[CW-1:H];
  assign rhs_bl = signed'({1'b0, q_dy[H-1:0]});
  assign rhs_bh = q_dy[CW-1:H];

  assign lhs_lo_nxt = q_dx * lhs_bl;
  assign lhs_hi_nxt = q_dx * lhs_bh;
  assign rhs_lo_nxt = q_qdx * rhs_bl;
  assign rhs_hi_nxt = q_qdx * rhs_bh;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= q_not_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_flags_r <= q_flags;
      lhs_lo_r   <= lhs_lo_nxt;
      lhs_hi_r   <= lhs_hi_nxt;
      rhs_lo_r   <= rhs_lo_nxt;
      rhs_hi_r   <= rhs_hi_nxt;
    end
  end

  assign lhs_full = FW'(lhs_lo_r) + (FW'(lhs_hi_r) <<< H);
  assign rhs_full = FW'(rhs_lo_r) + (FW'(rhs_hi_r) <<< H);
  assign lhs      = signed'(lhs_full[PW-1:0]);
  assign rhs      = signed'(rhs_full[PW-1:0]);

  always_comb begin
    counted = 1'b0;
    if (s1_flags_r.in_span) begin
      priority if (s1_flags_r.dy_pos) begin
        counted = (lhs >= rhs);
      end else if (s1_flags_r.dy_neg) begin
        counted = (lhs <= rhs);
      end else begin
        counted = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      parity_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r && s1_flags_r.last;
      if (s1_valid_r) begin
        if (s1_flags_r.last) begin
          parity_r <= 1'b0;
        end else begin
          parity_r <= parity_r ^ counted;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid_r && s1_flags_r.last) begin
      out_inside_r <= parity_r ^ counted;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_inside_res = out_inside_r;

  a_parity_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s1_valid_r && s1_flags_r.last) |=> !parity_r)
    else $error("parity not cleared after the last edge");

  a_freeze_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> ($stable(s1_valid_r) && $stable(parity_r)))
    else $error("back end moved while the result was held");

  a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_valid_r && s1_flags_r.last))
    else $error("result raised without a last edge");

endmodule

FILE: rtl/core/point_in_polygon_crossing.sv
// Top level of the point-in-polygon crossing block.
// Depends on pip_pkg, pip_front, pip_queue and pip_back.
//
// Each input transaction carries a query point, one polygon edge and a last-edge mark; the
// block takes one transaction per cycle while in_stall is low and returns one inside flag after
// the last edge of each polygon. A result passes through the four-entry queue behind the front
// end, the split cross-product stage and then the result register. While out_stall holds a
// result, the back end waits and the queue keeps taking edges until all four entries are in
// use, at which point in_stall rises.
module point_in_polygon_crossing #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [pip_pkg::X_W-1:0] in_query_x,
  input  logic signed [pip_pkg::Y_W-1:0] in_query_y,
  input  logic signed [pip_pkg::X_W-1:0] in_start_x,
  input  logic signed [pip_pkg::Y_W-1:0] in_start_y,
  input  logic signed [pip_pkg::X_W-1:0] in_end_x,
  input  logic signed [pip_pkg::Y_W-1:0] in_end_y,
  input  logic                           in_last_edge,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_inside_res
);

  localparam int CW      = COORD_WIDTH;
  localparam int ENTRY_W = pip_pkg::FLAGS_W + 4 * CW;

  pip_pkg::pip_flags_t    f_flags;
  logic signed [CW-1:0]   f_dx;
  logic signed [CW-1:0]   f_dy;
  logic signed [CW-1:0]   f_qdx;
  logic signed [CW-1:0]   f_qdy;
  logic [ENTRY_W-1:0]     push_data;
  logic [ENTRY_W-1:0]     pop_data;
  logic                   q_full;
  logic                   q_pop;
  logic                   q_not_empty;
  pip_pkg::pip_flags_t    q_flags;
  logic signed [CW-1:0]   q_dx;
  logic signed [CW-1:0]   q_dy;
  logic signed [CW-1:0]   q_qdx;
  logic signed [CW-1:0]   q_qdy;

  pip_front #(
    .COORD_WIDTH(CW)
  ) u_front (
    .query_x  (in_query_x),
    .query_y  (in_query_y),
    .start_x  (in_start_x),
    .start_y  (in_start_y),
    .end_x    (in_end_x),
    .end_y    (in_end_y),
    .last_edge(in_last_edge),
    .flags    (f_flags),
    .dx       (f_dx),
    .dy       (f_dy),
    .qdx      (f_qdx),
    .qdy      (f_qdy)
  );

  assign push_data = {f_flags, f_dx, f_dy, f_qdx, f_qdy};
  assign in_stall  = q_full;

  pip_queue #(
    .WIDTH(ENTRY_W)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_valid),
    .push_data(push_data),
    .full     (q_full),
    .pop      (q_pop),
    .not_empty(q_not_empty),
    .pop_data (pop_data)
  );

  assign {q_flags, q_dx, q_dy, q_qdx, q_qdy} = pop_data;

  pip_back #(
    .COORD_WIDTH(CW)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_not_empty   (q_not_empty),
    .q_pop         (q_pop),
    .q_flags       (q_flags),
    .q_dx          (q_dx),
    .q_dy          (q_dy),
    .q_qdx         (q_qdx),
    .q_qdy         (q_qdy),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_inside_res(out_inside_res)
  );

endmodule

FILE: verif/pip_inside_checker.sv
// Checker for the point-in-polygon crossing block: watches both channels, predicts each inside
// flag from the accepted edges and compares it with the block's result.
// Depends on pip_pkg.
module pip_inside_checker #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic signed [pip_pkg::X_W-1:0] in_query_x,
  input  logic signed [pip_pkg::Y_W-1:0] in_query_y,
  input  logic signed [pip_pkg::X_W-1:0] in_start_x,
  input  logic signed [pip_pkg::Y_W-1:0] in_start_y,
  input  logic signed [pip_pkg::X_W-1:0] in_end_x,
  input  logic signed [pip_pkg::Y_W-1:0] in_end_y,
  input  logic                           in_last_edge,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic                           out_inside_res,
  output int                             fail_count,
  output int                             outstanding
);

  logic ray_parity;
  logic inside_expected[$];
  logic next_parity;
  logic expected_inside;

  function automatic longint wrap_diff(input longint a, input longint b);
    logic signed [COORD_WIDTH-1:0] d;
    d = COORD_WIDTH'(a - b);
    return longint'(d);
  endfunction

  function automatic logic edge_crosses_ray(input longint qx, input longint qy,
                                            input longint ax, input longint ay,
                                            input longint bx, input longint by);
    longint maxx;
    longint miny;
    longint maxy;
    longint dx;
    longint dy;
    longint lhs;
    longint rhs;
    maxx = (ax > bx) ? ax : bx;
    miny = (ay < by) ? ay : by;
    maxy = (ay > by) ? ay : by;
    if (maxx >= qx && miny <= qy && qy < maxy) begin
      dx  = wrap_diff(bx, ax);
      dy  = wrap_diff(by, ay);
      lhs = dx * wrap_diff(qy, ay);
      rhs = wrap_diff(qx, ax) * dy;
      if (dy > 0) return lhs >= rhs;
      if (dy < 0) return lhs <= rhs;
    end
    return 1'b0;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      ray_parity <= 1'b0;
      inside_expected.delete();
      fail_count <= 0;
      outstanding <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (inside_expected.size() == 0) begin
          $error("inside_res: expected none, actual %0b", out_inside_res);
          fail_count <= fail_count + 1;
        end else begin
          expected_inside = inside_expected.pop_front();
          if (out_inside_res !== expected_inside) begin
            $error("inside_res: expected %0b, actual %0b", expected_inside, out_inside_res);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && !in_stall) begin
        next_parity = ray_parity ^ edge_crosses_ray(in_query_x, in_query_y, in_start_x,
                                                    in_start_y, in_end_x, in_end_y);
        if (in_last_edge) begin
          inside_expected.push_back(next_parity);
          ray_parity <= 1'b0;
        end else begin
          ray_parity <= next_parity;
        end
      end
      outstanding <= inside_expected.size();
    end
  end

endmodule

FILE: verif/tb_top.sv
// Testbench top for the point-in-polygon crossing block: drives edge transactions, stalls the
// result channel and gives the verdict.
// Depends on pip_pkg, point_in_polygon_crossing and pip_inside_checker.
module tb_top;

  typedef enum int {SHAPE_GRID, SHAPE_EXTREME, SHAPE_WIDE} shape_t;
  typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PERIODIC} stall_mode_t;

  localparam int RANDOM_ITEMS = 1500;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int X_MAX  = 180000000;
  localparam int Y_MAX  = 90000000;
  localparam int XF_MAX = 268435455;
  localparam int XF_MIN = -268435456;
  localparam int YF_MAX = 134217727;
  localparam int YF_MIN = -134217728;

  logic                           clk;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_stall;
  logic signed [pip_pkg::X_W-1:0] in_query_x;
  logic signed [pip_pkg::Y_W-1:0] in_query_y;
  logic signed [pip_pkg::X_W-1:0] in_start_x;
  logic signed [pip_pkg::Y_W-1:0] in_start_y;
  logic signed [pip_pkg::X_W-1:0] in_end_x;
  logic signed [pip_pkg::Y_W-1:0] in_end_y;
  logic                           in_last_edge;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic                           out_inside_res;

  int fail_count;
  int outstanding;
  int cycle_count = 0;
  int items_sent = 0;
  int burst_left = 1;
  int phase = 0;
  int mode_left = 0;
  int stall_on = 1;
  stall_mode_t stall_mode = STALL_NONE;

  point_in_polygon_crossing #(
    .COORD_WIDTH(32)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_query_x    (in_query_x),
    .in_query_y    (in_query_y),
    .in_start_x    (in_start_x),
    .in_start_y    (in_start_y),
    .in_end_x      (in_end_x),
    .in_end_y      (in_end_y),
    .in_last_edge  (in_last_edge),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_inside_res(out_inside_res)
  );

  pip_inside_checker #(
    .COORD_WIDTH(32)
  ) checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_query_x    (in_query_x),
    .in_query_y    (in_query_y),
    .in_start_x    (in_start_x),
    .in_start_y    (in_start_y),
    .in_end_x      (in_end_x),
    .in_end_y      (in_end_y),
    .in_last_edge  (in_last_edge),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_inside_res(out_inside_res),
    .fail_count    (fail_count),
    .outstanding   (outstanding)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[point_in_polygon_crossing] ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 2));
      mode_left <= $urandom_range(20, 200);
      stall_on <= $urandom_range(1, 12);
    end else begin
      mode_left <= mode_left - 1;
    end
    phase <= (phase + 1) % 16;
    unique case (stall_mode)
      STALL_NONE: begin
        out_stall <= 1'b0;
      end
      STALL_RANDOM: begin
        out_stall <= ($urandom_range(0, 9) < 3);
      end
      default: begin
        out_stall <= (phase < stall_on);
      end
    endcase
  end

  task automatic send_edge(input int qx, input int qy, input int ax, input int ay,
                           input int bx, input int by, input bit last);
    int gap;
    in_valid     <= 1'b1;
    in_query_x   <= pip_pkg::X_W'(qx);
    in_query_y   <= pip_pkg::Y_W'(qy);
    in_start_x   <= pip_pkg::X_W'(ax);
    in_start_y   <= pip_pkg::Y_W'(ay);
    in_end_x     <= pip_pkg::X_W'(bx);
    in_end_y     <= pip_pkg::Y_W'(by);
    in_last_edge <= last;
    do @(posedge clk); while (in_stall);
    items_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 2) : $urandom_range(3, 6);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 20);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  function automatic int pick_step();
    unique case ($urandom_range(0, 2))
      0: return 1;
      1: return $urandom_range(2, 1000);
      default: return 1000000;
    endcase
  endfunction

  task automatic send_polygon(input shape_t shape, input bit broken);
    int n;
    int qx;
    int qy;
    int base_x;
    int base_y;
    int step_x;
    int step_y;
    int vx[9];
    int vy[9];
    n = $urandom_range(3, 8);
    base_x = int'($urandom_range(0, 340000000)) - 170000000;
    base_y = int'($urandom_range(0, 160000000)) - 80000000;
    step_x = pick_step();
    step_y = pick_step();
    for (int i = 0; i <= n; i++) begin
      unique case (shape)
        SHAPE_GRID: begin
          vx[i] = base_x + (int'($urandom_range(0, 8)) - 4) * step_x;
          vy[i] = base_y + (int'($urandom_range(0, 8)) - 4) * step_y;
        end
        SHAPE_EXTREME: begin
          vx[i] = (int'($urandom_range(0, 4)) - 2) * 90000000;
          vy[i] = (int'($urandom_range(0, 4)) - 2) * 45000000;
        end
        default: begin
          vx[i] = int'($urandom_range(0, 2 * X_MAX)) - X_MAX;
          vy[i] = int'($urandom_range(0, 2 * Y_MAX)) - Y_MAX;
        end
      endcase
    end
    // The spare vertex at index n serves as the query point.
    qx = vx[n];
    qy = vy[n];
    for (int i = 0; i < n; i++) begin
      send_edge(qx, qy, vx[i], vy[i], vx[(i + 1) % n], vy[(i + 1) % n],
                broken ? ($urandom_range(0, 3) == 0) : (i == n - 1));
    end
  endtask

  initial begin
    int kind;
    in_valid     <= 1'b0;
    in_query_x   <= '0;
    in_query_y   <= '0;
    in_start_x   <= '0;
    in_start_y   <= '0;
    in_end_x     <= '0;
    in_end_y     <= '0;
    in_last_edge <= 1'b0;
    rst_n        <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_edge(5, 5, 0, 5, 10, 5, 1'b1);
    send_edge(5, 5, 0, 0, 10, 0, 1'b0);
    send_edge(5, 5, 10, 0, 10, 10, 1'b0);
    send_edge(5, 5, 10, 10, 0, 10, 1'b0);
    send_edge(5, 5, 0, 10, 0, 0, 1'b1);
    send_edge(15, 5, 0, 0, 10, 0, 1'b0);
    send_edge(15, 5, 10, 0, 10, 10, 1'b0);
    send_edge(15, 5, 10, 10, 0, 10, 1'b0);
    send_edge(15, 5, 0, 10, 0, 0, 1'b1);
    send_edge(0, 0, -X_MAX, -Y_MAX, X_MAX, Y_MAX, 1'b1);
    send_edge(0, 0, X_MAX, Y_MAX, -X_MAX, -Y_MAX, 1'b1);
    send_edge(0, 0, 5, 0, 5, 10, 1'b0);
    send_edge(0, 0, 5, -10, 5, 0, 1'b1);
    send_edge(X_MAX, 0, -X_MAX, -Y_MAX, X_MAX - 1, Y_MAX, 1'b1);
    send_edge(XF_MIN, YF_MIN, XF_MAX, YF_MIN, XF_MAX, YF_MAX, 1'b1);
    send_edge(XF_MAX, YF_MAX, XF_MIN, YF_MAX, XF_MAX, YF_MIN, 1'b1);
    send_edge(0, 0, 10, -10, -20, 10, 1'b1);

    while (items_sent < 17 + RANDOM_ITEMS) begin
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        repeat ($urandom_range(1, 5)) begin
          send_edge(int'($urandom), int'($urandom), int'($urandom), int'($urandom),
                    int'($urandom), int'($urandom), ($urandom_range(0, 2) == 0));
        end
      end else if (kind == 1) begin
        send_polygon(shape_t'($urandom_range(0, 2)), 1'b1);
      end else if (kind < 6) begin
        send_polygon(SHAPE_GRID, 1'b0);
      end else if (kind < 8) begin
        send_polygon(SHAPE_WIDE, 1'b0);
      end else begin
        send_polygon(SHAPE_EXTREME, 1'b0);
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("[point_in_polygon_crossing] OK");
    end else begin
      $display("[point_in_polygon_crossing] ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/pip_pkg.sv
rtl/core/pip_front.sv
rtl/core/pip_queue.sv
rtl/core/pip_back.sv
rtl/core/point_in_polygon_crossing.sv
verif/pip_inside_checker.sv
verif/tb_top.sv
